/* hdl/bbr_pkg.sv */
// Shared types, constants and helpers for the 3x3 RGB box blur.
package bbr_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;
  localparam int unsigned KSIZE  = 3;
  localparam int unsigned SUM_W  = 12;   // nine 8-bit values
  localparam int unsigned ROW_W  = 14;   // rows run up to height + 1 while draining
  localparam int unsigned IMG_W_W = 12;
  localparam int unsigned IMG_H_W = 13;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = 12'd640;
  localparam logic [IMG_H_W-1:0] IMG_H_RST = 13'd480;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // floor(x / 9) == (x * 7282) >> 16 for every x below 2296
  localparam int unsigned DIV9_MUL_W = 13;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
  localparam int unsigned DIV9_SHIFT = 16;
  localparam int unsigned PROD_W = SUM_W + DIV9_MUL_W;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;

  typedef logic [CH_W-1:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } pix_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  frame_last;
  } result_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_e;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  function automatic chan_t div9(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV9_MUL);
    return prod[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

/* hdl/bbr_in_if.sv */
// Input pixel channel: valid/ready with request type and RGB payload.
interface bbr_in_if;
  logic           valid;
  logic           ready;
  logic           req_type;
  bbr_pkg::chan_t in_red;
  bbr_pkg::chan_t in_green;
  bbr_pkg::chan_t in_blue;

  modport source (output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface

/* hdl/bbr_out_if.sv */
// Output pixel channel: valid/ready with filtered RGBA payload and frame end flag.
interface bbr_out_if;
  logic           valid;
  logic           ready;
  bbr_pkg::chan_t out_red;
  bbr_pkg::chan_t out_green;
  bbr_pkg::chan_t out_blue;
  bbr_pkg::chan_t out_alpha;
  logic           frame_last;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, frame_last,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, frame_last,
                  output ready);
endinterface

/* hdl/box_blur_3x3_rgb.sv */
// 3x3 box blur over a raster RGB stream: result = per-channel neighborhood sum / 9,
// zero outside the frame, alpha 255. While pix_i.ready is high the block takes one
// transaction per clock, pixels and flush ticks alike. A result passes the stage 1,
// tap and sum registers into the FIFO after the transaction that completes it, which
// is one row plus one pixel after its own pixel. After the last pixel of a frame,
// width + 1 flush ticks drain the bottom row; the last of them carries frame_last.
// Width and height are sampled at the first pixel of each frame. The two previous
// rows sit in one line memory of MAX_WIDTH x 48 bits, read and written back once per
// transaction; back-to-back hits on the same column are forwarded. Results queue in
// an 8-entry output FIFO; pix_i.ready drops only while the FIFO and the transactions
// in flight together fill it. The line memory needs no clearing pass after reset.
module box_blur_3x3_rgb #(
  parameter int unsigned MAX_WIDTH = bbr_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bbr_in_if.sink                           pix_i,
  bbr_out_if.source                        pix_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bbr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [bbr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bbr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned CNT_W  = COL_W + 1;
  localparam int unsigned ROW1_W = bbr_pkg::ROW_W + 1;
  localparam int unsigned OCC_W  = bbr_pkg::FIFO_CNT_W + 1;
  localparam int unsigned PIX_W  = bbr_pkg::PIX_W;
  localparam int unsigned KSIZE  = bbr_pkg::KSIZE;

  typedef struct packed {
    logic [COL_W-1:0] col;
    bbr_pkg::pix_t    pix;
    logic             col0;
    logic             emit;
    logic             mask_top;
    logic             mask_bot;
    logic             last;
  } s1_ctrl_t;

  // ---------------- configuration registers ----------------
  logic [bbr_pkg::IMG_W_W-1:0] img_w_q;
  logic [bbr_pkg::IMG_H_W-1:0] img_h_q;
  logic                        cfg_wr;
  bbr_pkg::reg_idx_e           reg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = bbr_pkg::reg_idx_e'(paddr[bbr_pkg::APB_ADDR_W-1]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= bbr_pkg::IMG_W_RST;
      img_h_q <= bbr_pkg::IMG_H_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        bbr_pkg::REG_IMAGE_WIDTH:  img_w_q <= pwdata[bbr_pkg::IMG_W_W-1:0];
        bbr_pkg::REG_IMAGE_HEIGHT: img_h_q <= pwdata[bbr_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bbr_pkg::REG_IMAGE_WIDTH:  prdata = bbr_pkg::APB_DATA_W'(img_w_q);
      bbr_pkg::REG_IMAGE_HEIGHT: prdata = bbr_pkg::APB_DATA_W'(img_h_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- stage 0: position tracking, line memory read ----------------
  logic [COL_W-1:0]         col_q, col_d;
  logic [bbr_pkg::ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0]         pending_q, pending_d;
  logic [CNT_W-1:0]         frame_w_q, frame_w_d;
  logic [bbr_pkg::ROW_W-1:0] frame_h_q, frame_h_d;

  logic                     in_take, act, flushing, first, last;
  logic [31:0]              iw32;
  logic [CNT_W-1:0]         fw_cfg, fw_eff, col_inc;
  logic [bbr_pkg::ROW_W-1:0] fh_cfg, fh_eff, row_inc, center;
  logic                     emit0, mask_top0, mask_bot0;
  bbr_pkg::pix_t            pix0;

  assign in_take  = pix_i.valid && pix_i.ready;
  assign flushing = (pending_q != '0);
  assign act      = in_take && (flushing || pix_i.req_type != bbr_pkg::REQ_FLUSH);
  assign first    = !flushing && (row_q == '0) && (col_q == '0);
  assign last     = flushing && (pending_q == CNT_W'(1));

  assign iw32 = 32'(img_w_q);

  always_comb begin
    if (img_w_q == '0) begin
      fw_cfg = CNT_W'(1);
    end else if (iw32 > MAX_WIDTH) begin
      fw_cfg = CNT_W'(MAX_WIDTH);
    end else begin
      fw_cfg = CNT_W'(img_w_q);
    end
  end

  assign fh_cfg  = (img_h_q == '0) ? bbr_pkg::ROW_W'(1) : bbr_pkg::ROW_W'(img_h_q);
  assign fw_eff  = first ? fw_cfg : frame_w_q;
  assign fh_eff  = first ? fh_cfg : frame_h_q;
  assign col_inc = CNT_W'(col_q) + CNT_W'(1);
  assign row_inc = row_q + bbr_pkg::ROW_W'(1);

  assign pix0 = flushing ? '0 : bbr_pkg::pix_t'({pix_i.in_red, pix_i.in_green, pix_i.in_blue});

  // column 0 closes the last column of the row two back
  always_comb begin
    if (col_q == '0) begin
      emit0  = (row_q >= bbr_pkg::ROW_W'(2));
      center = row_q - bbr_pkg::ROW_W'(2);
    end else begin
      emit0  = (row_q >= bbr_pkg::ROW_W'(1));
      center = row_q - bbr_pkg::ROW_W'(1);
    end
    mask_top0 = (center == '0);
    mask_bot0 = (ROW1_W'(center) + ROW1_W'(1)) >= ROW1_W'(fh_eff);
  end

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    pending_d = pending_q;
    frame_w_d = frame_w_q;
    frame_h_d = frame_h_q;
    if (act) begin
      if (first) begin
        frame_w_d = fw_cfg;
        frame_h_d = fh_cfg;
      end
      if (flushing) begin
        pending_d = pending_q - CNT_W'(1);
      end
      if (last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= fw_eff) begin
        col_d = '0;
        row_d = row_inc;
        if (!flushing && row_inc >= fh_eff) begin
          pending_d = fw_eff + CNT_W'(1);
        end
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pending_q <= '0;
      frame_w_q <= CNT_W'(1);
      frame_h_q <= bbr_pkg::ROW_W'(1);
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      pending_q <= pending_d;
      frame_w_q <= frame_w_d;
      frame_h_q <= frame_h_d;
    end
  end

  // ---------------- line memory: {upper, lower} per column ----------------
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;
  logic [2*PIX_W-1:0] fwd_data_q;
  logic               fwd_q;
  logic               s1_v_q;
  s1_ctrl_t           s1_q;
  bbr_pkg::pix_t      up_eff, lo_eff;

  always_ff @(posedge clk_i) begin
    if (act) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_v_q) begin
      line_mem[s1_q.col] <= {lo_eff, s1_q.pix};
    end
  end

  // read in the same cycle as the write to that column sees stale data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      fwd_q  <= act && s1_v_q && (col_q == s1_q.col);
      s1_v_q <= act;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= {lo_eff, s1_q.pix};
    if (act) begin
      s1_q <= '{col: col_q, pix: pix0, col0: (col_q == '0), emit: emit0,
                mask_top: mask_top0, mask_bot: mask_bot0, last: last};
    end
  end

  // ---------------- stage 1: window update and tap selection ----------------
  assign up_eff = fwd_q ? bbr_pkg::pix_t'(fwd_data_q[2*PIX_W-1:PIX_W])
                        : bbr_pkg::pix_t'(rd_q[2*PIX_W-1:PIX_W]);
  assign lo_eff = fwd_q ? bbr_pkg::pix_t'(fwd_data_q[PIX_W-1:0])
                        : bbr_pkg::pix_t'(rd_q[PIX_W-1:0]);

  bbr_pkg::pix_t win_q [KSIZE][KSIZE];
  bbr_pkg::pix_t win_d [KSIZE][KSIZE];
  bbr_pkg::pix_t taps  [KSIZE][KSIZE];
  bbr_pkg::pix_t new_col [KSIZE];

  assign new_col[0] = up_eff;
  assign new_col[1] = lo_eff;
  assign new_col[2] = s1_q.pix;

  always_comb begin
    win_d = win_q;
    taps  = win_q;
    if (s1_v_q) begin
      for (int k = 0; k < KSIZE; k++) begin
        if (s1_q.col0) begin
          taps[k][0]  = win_q[k][1];
          taps[k][1]  = win_q[k][2];
          taps[k][2]  = '0;
          win_d[k][0] = '0;
          win_d[k][1] = '0;
        end else begin
          win_d[k][0] = win_q[k][1];
          win_d[k][1] = win_q[k][2];
          taps[k][0]  = win_q[k][1];
          taps[k][1]  = win_q[k][2];
          taps[k][2]  = new_col[k];
        end
        win_d[k][2] = new_col[k];
      end
      for (int j = 0; j < KSIZE; j++) begin
        if (s1_q.mask_top) taps[0][j] = '0;
        if (s1_q.mask_bot) taps[KSIZE-1][j] = '0;
      end
      // end of drain: next frame starts from an empty window
      if (s1_q.last) begin
        win_d = '{default: '0};
      end
    end
  end

  bbr_pkg::pix_t taps_q [KSIZE][KSIZE];
  logic          t_v_q, t_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '{default: '0};
      t_v_q <= 1'b0;
    end else begin
      win_q <= win_d;
      t_v_q <= s1_v_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    taps_q   <= taps;
    t_last_q <= s1_q.last;
  end

  // ---------------- stage 2: channel sums ----------------
  logic [bbr_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [bbr_pkg::SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic                      sum_v_q, sum_last_q;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < KSIZE; k++) begin
      for (int j = 0; j < KSIZE; j++) begin
        sum_r = sum_r + bbr_pkg::SUM_W'(taps_q[k][j].r);
        sum_g = sum_g + bbr_pkg::SUM_W'(taps_q[k][j].g);
        sum_b = sum_b + bbr_pkg::SUM_W'(taps_q[k][j].b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
    end else begin
      sum_v_q <= t_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_r_q    <= sum_r;
    sum_g_q    <= sum_g;
    sum_b_q    <= sum_b;
    sum_last_q <= t_last_q;
  end

  // ---------------- stage 3: divide by nine into output FIFO ----------------
  bbr_pkg::result_t                fifo_q [bbr_pkg::FIFO_DEPTH];
  logic [bbr_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [bbr_pkg::FIFO_CNT_W-1:0]  fifo_cnt_q;
  logic                            push, pop;
  logic [OCC_W-1:0]                occ;

  assign push = sum_v_q;
  assign pop  = pix_o.valid && pix_o.ready;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{red:   bbr_pkg::div9(sum_r_q),
                            green: bbr_pkg::div9(sum_g_q),
                            blue:  bbr_pkg::div9(sum_b_q),
                            frame_last: sum_last_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + bbr_pkg::FIFO_PTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + bbr_pkg::FIFO_PTR_W'(1);
      case ({push, pop})
        2'b10:   fifo_cnt_q <= fifo_cnt_q + bbr_pkg::FIFO_CNT_W'(1);
        2'b01:   fifo_cnt_q <= fifo_cnt_q - bbr_pkg::FIFO_CNT_W'(1);
        default: ;
      endcase
    end
  end

  assign pix_o.valid      = (fifo_cnt_q != '0);
  assign pix_o.out_red    = fifo_q[rd_ptr_q].red;
  assign pix_o.out_green  = fifo_q[rd_ptr_q].green;
  assign pix_o.out_blue   = fifo_q[rd_ptr_q].blue;
  assign pix_o.frame_last = fifo_q[rd_ptr_q].frame_last;
  assign pix_o.out_alpha  = bbr_pkg::ALPHA_OPAQUE;

  // every transaction in flight may still land in the FIFO
  assign occ = OCC_W'(fifo_cnt_q) + OCC_W'(s1_v_q) + OCC_W'(t_v_q) + OCC_W'(sum_v_q);
  assign pix_i.ready = (occ < OCC_W'(bbr_pkg::FIFO_DEPTH));

  // ---------------- assertions ----------------
  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ <= OCC_W'(bbr_pkg::FIFO_DEPTH))
    else $error("output FIFO and in-flight results exceed its depth");

  a_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q < frame_w_q)
    else $error("column count reached frame width");

  a_drain_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q != '0) |-> (row_q >= frame_h_q))
    else $error("drain pending before the last row finished");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act && last) |=> (row_q == '0 && col_q == '0 && pending_q == '0))
    else $error("position not cleared after the last drain transaction");

  a_fwd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_v_q)
    else $error("forwarded line data without a transaction in stage 1");

endmodule
